>>> src/ball_position_from_image_circle_core_assert.svh
// assertion macros for the ball position core
`ifndef BALL_POSITION_FROM_IMAGE_CIRCLE_CORE_ASSERT_SVH
`define BALL_POSITION_FROM_IMAGE_CIRCLE_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define BPIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define BPIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bpic_pkg.sv
// shared types and constants of the ball position core
package bpic_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned FocalW  = 16;
  localparam int unsigned ImgW    = 13;
  localparam int unsigned BallW   = 16;
  localparam int unsigned PosW    = 24;
  localparam int unsigned CfgIdxW = 2;

  // radicand and divider widths of the pipelined units
  localparam int unsigned LRadW   = 34;
  localparam int unsigned QRadW   = 72;
  localparam int unsigned ZNumW   = 60;
  localparam int unsigned ZDenW   = 41;
  localparam int unsigned LatNumW = 57;

  localparam logic [FocalW-1:0] FocalRst  = 16'd8864;
  localparam logic [ImgW-1:0]   WidthRst  = 13'd640;
  localparam logic [ImgW-1:0]   HeightRst = 13'd480;
  localparam logic [BallW-1:0]  BallRst   = 16'd576;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFocal  = 2'd0,
    CfgWidth  = 2'd1,
    CfgHeight = 2'd2,
    CfgBall   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              sx;
    logic              sy;
    logic [CoordW-1:0] ax;
    logic [CoordW-1:0] ay;
    logic              ok;
  } pos_t;

  typedef struct packed {
    pos_t              p;
    logic [CoordW-1:0] a;
  } geo_t;

  typedef struct packed {
    logic [PosW-1:0] pz;
    logic            sx;
    logic            ok;
  } lat_t;

endpackage

>>> src/bpic_sqrt_pipe.sv
// pipelined integer square root, one root bit per register stage
module bpic_sqrt_pipe #(
  parameter int unsigned RadW  = bpic_pkg::LRadW,
  parameter int unsigned SideW = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_vld_i,
  input  logic [RadW-1:0]       rad_i,
  input  logic [SideW-1:0]      side_i,
  output logic                  out_vld_o,
  output logic [RadW/2-1:0]     root_o,
  output logic [SideW-1:0]      side_o
);

  localparam int unsigned RootW = RadW / 2;
  localparam int unsigned RemW  = RootW + 2;

  logic                 vld_q  [RootW];
  logic [RadW-1:0]      rad_q  [RootW];
  logic [RemW-1:0]      rem_q  [RootW];
  logic [RootW-1:0]     root_q [RootW];
  logic [SideW-1:0]     side_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic             vld_in;
    logic [RadW-1:0]  rad_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [SideW-1:0] side_in;
    logic [RemW+1:0]  rem_x;
    logic [RemW+1:0]  trial;
    logic [RemW+1:0]  diff;
    logic             take;
    logic [RemW-1:0]  rem_d;
    logic [RootW-1:0] root_d;
    logic [RadW-1:0]  rad_d;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down two radicand bits, try 4*root+1
    assign rem_x  = {rem_in, rad_in[RadW-1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign take   = (rem_x >= trial);
    assign diff   = rem_x - trial;
    assign rem_d  = take ? diff[RemW-1:0] : rem_x[RemW-1:0];
    assign root_d = {root_in[RootW-2:0], take};
    assign rad_d  = {rad_in[RadW-3:0], 2'b00};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= rad_d;
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
      side_q[k] <= side_in;
    end
  end

  assign out_vld_o = vld_q[RootW-1];
  assign root_o    = root_q[RootW-1];
  assign side_o    = side_q[RootW-1];

endmodule

>>> src/bpic_div_pipe.sv
// pipelined restoring divider, one quotient bit per register stage
module bpic_div_pipe #(
  parameter int unsigned NumW  = bpic_pkg::ZNumW,
  parameter int unsigned DenW  = bpic_pkg::ZDenW,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_vld_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             out_vld_o,
  output logic [NumW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic             vld_q  [NumW];
  logic [NumW-1:0]  nq_q   [NumW];
  logic [DenW-1:0]  rem_q  [NumW];
  logic [DenW-1:0]  den_q  [NumW];
  logic [SideW-1:0] side_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic             vld_in;
    logic [NumW-1:0]  nq_in;
    logic [DenW-1:0]  rem_in;
    logic [DenW-1:0]  den_in;
    logic [SideW-1:0] side_in;
    logic [DenW:0]    rem_x;
    logic [DenW:0]    diff;
    logic             take;
    logic [DenW-1:0]  rem_d;
    logic [NumW-1:0]  nq_d;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld_i;
      assign nq_in   = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // numerator bits leave at the top, quotient bits enter at the bottom
    assign rem_x = {rem_in, nq_in[NumW-1]};
    assign take  = (rem_x >= {1'b0, den_in});
    assign diff  = rem_x - {1'b0, den_in};
    assign rem_d = take ? diff[DenW-1:0] : rem_x[DenW-1:0];
    assign nq_d  = {nq_in[NumW-2:0], take};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      nq_q[k]   <= nq_d;
      rem_q[k]  <= rem_d;
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
    end
  end

  assign out_vld_o = vld_q[NumW-1];
  assign quo_o     = nq_q[NumW-1];
  assign side_o    = side_q[NumW-1];

endmodule

>>> src/ball_position_from_image_circle_core.sv
// top level: ball position in camera space from a detected image circle
//
//  channel  signals                                        direction  handshake
//  input    center_x_i center_y_i circle_radius_i          in         start, busy
//  result   pos_x_o pos_y_o pos_z_o valid_res_o            out        done_o strobe
//  config   cfg_idx_i cfg_data_i                           in         cfg_we_i
//
//  a beat is taken every cycle; busy never rises
//  done_o rises in the same cycle as the result beat is shown, both set by 180
//  register stages, most of them in the bit-per-stage units: 17-stage and
//  36-stage roots, 60-stage and 57-stage dividers
//  reset clears every stage valid and the registers to their defaults
//  the result side has no stall, the pipeline never holds
module ball_position_from_image_circle_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [bpic_pkg::CoordW-1:0]   center_x_i,
  input  logic [bpic_pkg::CoordW-1:0]   center_y_i,
  input  logic [bpic_pkg::CoordW-1:0]   circle_radius_i,
  output logic                          done_o,
  output logic signed [bpic_pkg::PosW-1:0] pos_x_o,
  output logic signed [bpic_pkg::PosW-1:0] pos_y_o,
  output logic [bpic_pkg::PosW-1:0]     pos_z_o,
  output logic                          valid_res_o,
  input  logic                          cfg_we_i,
  input  logic [bpic_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpic_pkg::FocalW-1:0]   cfg_data_i
);

  localparam logic [bpic_pkg::ZNumW-1:0] ZClamp = 60'h000_0100_0000_0000;
  localparam logic [bpic_pkg::ZNumW-1:0] ZSat   = 60'h000_0000_00FF_FFFF;

  function automatic logic [23:0] sat_lat(logic [bpic_pkg::LatNumW-1:0] v, logic neg);
    logic [23:0] r;
    if (neg) begin
      r = (v > 57'h80_0000) ? 24'h80_0000 : (24'h00_0000 - v[23:0]);
    end else begin
      r = (v > 57'h7F_FFFF) ? 24'h7F_FFFF : v[23:0];
    end
    return r;
  endfunction

  // configuration
  logic [15:0] focal_q;
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [15:0] ball_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q  <= bpic_pkg::FocalRst;
      width_q  <= bpic_pkg::WidthRst;
      height_q <= bpic_pkg::HeightRst;
      ball_q   <= bpic_pkg::BallRst;
    end else if (cfg_we_i) begin
      unique case (bpic_pkg::cfg_idx_e'(cfg_idx_i))
        bpic_pkg::CfgFocal:  focal_q  <= cfg_data_i;
        bpic_pkg::CfgWidth:  width_q  <= cfg_data_i[12:0];
        bpic_pkg::CfgHeight: height_q <= cfg_data_i[12:0];
        bpic_pkg::CfgBall:   ball_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: recenter, y up
  logic               acc;
  logic signed [17:0] xo;
  logic signed [17:0] yo;
  logic [17:0]        xo_neg;
  logic [17:0]        yo_neg;
  bpic_pkg::geo_t     s0_d;
  bpic_pkg::geo_t     s0_q;
  logic               s0_vld_q;

  assign acc    = start & ~busy;
  assign xo     = $signed({2'b00, center_x_i}) - $signed({2'b00, width_q[12:1], 4'b0000});
  assign yo     = $signed({2'b00, height_q[12:1], 4'b0000}) - $signed({2'b00, center_y_i});
  assign xo_neg = 18'd0 - xo;
  assign yo_neg = 18'd0 - yo;

  always_comb begin
    s0_d.p.sx = xo[17];
    s0_d.p.sy = yo[17];
    s0_d.p.ax = xo[17] ? xo_neg[15:0] : xo[15:0];
    s0_d.p.ay = yo[17] ? yo_neg[15:0] : yo[15:0];
    s0_d.p.ok = (circle_radius_i != '0) && (focal_q != '0);
    s0_d.a    = circle_radius_i;
  end

  // stage 1: squared offset
  logic [31:0]    ax2;
  logic [31:0]    ay2;
  logic [32:0]    s1_sq_q;
  bpic_pkg::geo_t s1_q;
  logic           s1_vld_q;

  assign ax2 = s0_q.p.ax * s0_q.p.ax;
  assign ay2 = s0_q.p.ay * s0_q.p.ay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= acc;
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q    <= s0_d;
    s1_q    <= s0_q;
    s1_sq_q <= {1'b0, ax2} + {1'b0, ay2};
  end

  // radial offset L
  logic           l_vld;
  logic [16:0]    l_root;
  bpic_pkg::geo_t l_side;

  bpic_sqrt_pipe #(
    .RadW  (bpic_pkg::LRadW),
    .SideW ($bits(bpic_pkg::geo_t))
  ) u_sqrt_l (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s1_vld_q),
    .rad_i     ({1'b0, s1_sq_q}),
    .side_i    (s1_q),
    .out_vld_o (l_vld),
    .root_o    (l_root),
    .side_o    (l_side)
  );

  // stages 2 to 5: build N^2 + M^2 and (L^2 + f^2) * 65536
  logic [33:0]    s2_pll_q;
  logic [32:0]    s2_pla_q;
  logic [31:0]    s2_pff_q;
  bpic_pkg::geo_t s2_q;
  logic           s2_vld_q;
  logic [34:0]    s3_n_q;
  logic [31:0]    s3_m_q;
  logic [34:0]    s3_t_q;
  bpic_pkg::geo_t s3_q;
  logic           s3_vld_q;
  logic [33:0]    s4_hh_q;
  logic [34:0]    s4_hl_q;
  logic [35:0]    s4_ll_q;
  logic [63:0]    s4_mm_q;
  logic [34:0]    s4_t_q;
  bpic_pkg::geo_t s4_q;
  logic           s4_vld_q;
  logic [71:0]    s5_rq_q;
  logic [71:0]    s5_rs_q;
  bpic_pkg::geo_t s5_q;
  logic           s5_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= l_vld;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_pll_q <= l_root * l_root;
    s2_pla_q <= l_root * l_side.a;
    s2_pff_q <= focal_q * focal_q;
    s2_q     <= l_side;
    s3_n_q   <= 35'(s2_pff_q) + 35'(s2_pll_q) + 35'(s2_pla_q);
    s3_m_q   <= s2_q.a * focal_q;
    s3_t_q   <= 35'(s2_pll_q) + 35'(s2_pff_q);
    s3_q     <= s2_q;
    // N split in two halves so each product stays narrow
    s4_hh_q  <= s3_n_q[34:18] * s3_n_q[34:18];
    s4_hl_q  <= s3_n_q[34:18] * s3_n_q[17:0];
    s4_ll_q  <= s3_n_q[17:0] * s3_n_q[17:0];
    s4_mm_q  <= s3_m_q * s3_m_q;
    s4_t_q   <= s3_t_q;
    s4_q     <= s3_q;
    s5_rq_q  <= (72'(s4_hh_q) << 36) + (72'(s4_hl_q) << 19) + 72'(s4_ll_q) + 72'(s4_mm_q);
    s5_rs_q  <= {21'd0, s4_t_q, 16'd0};
    s5_q     <= s4_q;
  end

  // Q and S roots side by side
  logic                    qr_vld;
  logic [35:0]             qr_root;
  bpic_pkg::pos_t          qr_side;
  logic                    sr_vld;
  logic [35:0]             sr_root;
  logic [15:0]             sr_side;

  bpic_sqrt_pipe #(
    .RadW  (bpic_pkg::QRadW),
    .SideW ($bits(bpic_pkg::pos_t))
  ) u_sqrt_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s5_vld_q),
    .rad_i     (s5_rq_q),
    .side_i    (s5_q.p),
    .out_vld_o (qr_vld),
    .root_o    (qr_root),
    .side_o    (qr_side)
  );

  bpic_sqrt_pipe #(
    .RadW  (bpic_pkg::QRadW),
    .SideW (bpic_pkg::CoordW)
  ) u_sqrt_s (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s5_vld_q),
    .rad_i     (s5_rs_q),
    .side_i    (s5_q.a),
    .out_vld_o (sr_vld),
    .root_o    (sr_root),
    .side_o    (sr_side)
  );

  // stage 6: depth numerator and denominator
  logic [51:0]    s6_num_q;
  logic [40:0]    s6_den_q;
  bpic_pkg::pos_t s6_q;
  logic           s6_vld_q;

  always_ff @(posedge clk_i) begin
    s6_num_q <= ball_q * qr_root;
    s6_den_q <= sr_side * sr_root[24:0];
    s6_q     <= qr_side;
  end

  logic                  zd_vld;
  logic [59:0]           zd_quo;
  bpic_pkg::pos_t        zd_side;

  bpic_div_pipe #(
    .NumW  (bpic_pkg::ZNumW),
    .DenW  (bpic_pkg::ZDenW),
    .SideW ($bits(bpic_pkg::pos_t))
  ) u_div_z (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s6_vld_q),
    .num_i     ({s6_num_q, 8'd0}),
    .den_i     (s6_den_q),
    .side_i    (s6_q),
    .out_vld_o (zd_vld),
    .quo_o     (zd_quo),
    .side_o    (zd_side)
  );

  // stage 7: saturate depth, clamp before the lateral products
  logic [23:0]    s7_pz_q;
  logic [40:0]    s7_zc_q;
  bpic_pkg::pos_t s7_q;
  logic           s7_vld_q;
  // stage 8: lateral numerators
  logic [56:0]    s8_px_q;
  logic [56:0]    s8_py_q;
  bpic_pkg::lat_t s8_q;
  logic           s8_sy_q;
  logic           s8_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= qr_vld & sr_vld;
      s7_vld_q <= zd_vld;
      s8_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_pz_q  <= (zd_quo > ZSat) ? 24'hFF_FFFF : zd_quo[23:0];
    s7_zc_q  <= (zd_quo > ZClamp) ? ZClamp[40:0] : zd_quo[40:0];
    s7_q     <= zd_side;
    s8_px_q  <= s7_zc_q * s7_q.ax;
    s8_py_q  <= s7_zc_q * s7_q.ay;
    s8_q.pz  <= s7_pz_q;
    s8_q.sx  <= s7_q.sx;
    s8_q.ok  <= s7_q.ok;
    s8_sy_q  <= s7_q.sy;
  end

  logic           xd_vld;
  logic [56:0]    xd_quo;
  bpic_pkg::lat_t xd_side;
  logic           yd_vld;
  logic [56:0]    yd_quo;
  logic           yd_side;

  bpic_div_pipe #(
    .NumW  (bpic_pkg::LatNumW),
    .DenW  (bpic_pkg::FocalW),
    .SideW ($bits(bpic_pkg::lat_t))
  ) u_div_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s8_vld_q),
    .num_i     (s8_px_q),
    .den_i     (focal_q),
    .side_i    (s8_q),
    .out_vld_o (xd_vld),
    .quo_o     (xd_quo),
    .side_o    (xd_side)
  );

  bpic_div_pipe #(
    .NumW  (bpic_pkg::LatNumW),
    .DenW  (bpic_pkg::FocalW),
    .SideW (1)
  ) u_div_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s8_vld_q),
    .num_i     (s8_py_q),
    .den_i     (focal_q),
    .side_i    (s8_sy_q),
    .out_vld_o (yd_vld),
    .quo_o     (yd_quo),
    .side_o    (yd_side)
  );

  // output register
  logic        done_q;
  logic [23:0] pos_x_q;
  logic [23:0] pos_y_q;
  logic [23:0] pos_z_q;
  logic        valid_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= xd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_q     <= xd_side.ok ? sat_lat(xd_quo, xd_side.sx) : 24'd0;
    pos_y_q     <= xd_side.ok ? sat_lat(yd_quo, yd_side) : 24'd0;
    pos_z_q     <= xd_side.ok ? xd_side.pz : 24'd0;
    valid_res_q <= xd_side.ok;
  end

  assign done_o      = done_q;
  assign pos_x_o     = $signed(pos_x_q);
  assign pos_y_o     = $signed(pos_y_q);
  assign pos_z_o     = pos_z_q;
  assign valid_res_o = valid_res_q;

`include "ball_position_from_image_circle_core_assert.svh"

  `BPIC_ASSERT_IMP(a_root_align, 1'b1, qr_vld == sr_vld, "root units out of step")
  `BPIC_ASSERT_IMP(a_div_align, 1'b1, xd_vld == yd_vld, "lateral dividers out of step")
  `BPIC_ASSERT_NXT(a_strobe_follows, xd_vld, done_o, "finished beat not shown")
  `BPIC_ASSERT_IMP(a_strobe_source, done_o, $past(xd_vld), "strobe without a finished beat")
  `BPIC_ASSERT_IMP(a_invalid_zero, done_o && !valid_res_o,
                   pos_x_o == '0 && pos_y_o == '0 && pos_z_o == '0, "invalid result not zero")

endmodule

>>> tb/tb_ball_position_from_image_circle_core.sv
// testbench of the ball position core: directed and random circles checked against a predictor
module tb_ball_position_from_image_circle_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Latency = 180;

  typedef struct {
    logic signed [bpic_pkg::PosW-1:0] px;
    logic signed [bpic_pkg::PosW-1:0] py;
    logic [bpic_pkg::PosW-1:0]        pz;
    logic                             vld;
  } ball_pos_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [bpic_pkg::CoordW-1:0] center_x_i = '0, center_y_i = '0, circle_radius_i = '0;
  logic done_o, valid_res_o;
  logic signed [bpic_pkg::PosW-1:0] pos_x_o, pos_y_o;
  logic [bpic_pkg::PosW-1:0] pos_z_o;
  logic cfg_we_i = 1'b0;
  logic [bpic_pkg::CfgIdxW-1:0] cfg_idx_i = bpic_pkg::CfgFocal;
  logic [bpic_pkg::FocalW-1:0] cfg_data_i = '0;

  // predictor copy of the registers
  logic [bpic_pkg::FocalW-1:0] focal_q;
  logic [bpic_pkg::ImgW-1:0]   width_q, height_q;
  logic [bpic_pkg::BallW-1:0]  ball_q;

  ball_pos_t pending_pos[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;

  ball_position_from_image_circle_core u_dut (.*);

  always #6ns clk_i = ~clk_i;

  initial begin
    #600ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0] q;
    logic [63:0] c;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      c = q | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) q = c;
    end
    return q;
  endfunction

  function automatic logic [bpic_pkg::PosW-1:0] side_offset(logic [63:0] z,
                                                            logic signed [31:0] off,
                                                            logic [bpic_pkg::FocalW-1:0] f);
    logic [63:0] mag;
    logic [63:0] v;
    mag = off < 0 ? 64'(-off) : 64'(off);
    v = (z * mag) / f;
    if (off < 0) begin
      if (v > 64'h800000) v = 64'h800000;
      return bpic_pkg::PosW'(25'h1000000 - v);
    end
    if (v > 64'h7FFFFF) v = 64'h7FFFFF;
    return bpic_pkg::PosW'(v);
  endfunction

  function automatic ball_pos_t locate_ball(logic [15:0] cx, logic [15:0] cy, logic [15:0] a);
    ball_pos_t r;
    logic signed [31:0] xo, yo;
    logic [63:0] l, n, m, q, s, z, f;
    r = '{0, 0, 0, 1'b0};
    f = 64'(focal_q);
    if (a == 0 || f == 0) return r;
    xo = $signed({16'd0, cx}) - $signed({15'd0, width_q >> 1, 4'd0});
    yo = $signed({15'd0, height_q >> 1, 4'd0}) - $signed({16'd0, cy});
    l = isqrt(128'(64'(xo * xo) + 64'(yo * yo)));
    n = f * f + l * l + l * a;
    m = a * f;
    q = isqrt({64'd0, n} * {64'd0, n} + {64'd0, m} * {64'd0, m});
    s = isqrt(128'((l * l + f * f) << 16));
    z = ((ball_q * q) << 8) / (a * s);
    r.pz = z > 64'hFFFFFF ? 24'hFFFFFF : z[23:0];
    if (z > (64'd1 << 40)) z = 64'd1 << 40;
    r.px = side_offset(z, xo, f[15:0]);
    r.py = side_offset(z, yo, f[15:0]);
    r.vld = 1'b1;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    ball_pos_t e;
    if (rst_ni && done_o) begin
      if (pending_pos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        e = pending_pos.pop_front();
        if (pos_x_o !== e.px || pos_y_o !== e.py || pos_z_o !== e.pz ||
            valid_res_o !== e.vld) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%0d y=%0d z=%0d v=%0b got x=%0d y=%0d z=%0d v=%0b",
                     e.px, e.py, e.pz, e.vld, pos_x_o, pos_y_o, pos_z_o, valid_res_o);
        end
      end
    end
  end

  task automatic send_circle(logic [15:0] cx, logic [15:0] cy, logic [15:0] a);
    // bursts with random gaps between most of them, start stays high inside a burst
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    center_x_i <= cx;
    center_y_i <= cy;
    circle_radius_i <= a;
    do @(posedge clk_i); while (busy);
    pending_pos.push_back(locate_ball(cx, cy, a));
    @(negedge clk_i);
  endtask

  // leaves the write enable high, the caller drops it after the last write
  task automatic write_reg(bpic_pkg::cfg_idx_e idx, logic [bpic_pkg::FocalW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    case (idx)
      bpic_pkg::CfgFocal:  focal_q = val;
      bpic_pkg::CfgWidth:  width_q = val[bpic_pkg::ImgW-1:0];
      bpic_pkg::CfgHeight: height_q = val[bpic_pkg::ImgW-1:0];
      default:             ball_q = val;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_pos.size() != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
  endtask

  task automatic set_camera(logic [15:0] f, logic [15:0] w, logic [15:0] h, logic [15:0] b);
    drain();
    write_reg(bpic_pkg::CfgFocal, f);
    write_reg(bpic_pkg::CfgWidth, w);
    write_reg(bpic_pkg::CfgHeight, h);
    write_reg(bpic_pkg::CfgBall, b);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    logic [15:0] mid_x, mid_y;
    mid_x = 16'((width_q >> 1) << 4);
    mid_y = 16'((height_q >> 1) << 4);
    send_circle(mid_x, mid_y, 16'd160);     // on-axis center
    send_circle(mid_x, mid_y, 16'd0);       // zero radius
    send_circle(16'd100, 16'd200, 16'd0);
    send_circle(16'h0000, 16'h0000, 16'h0001);
    send_circle(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_circle(16'h0000, 16'hFFFF, 16'h0001);
    send_circle(16'hFFFF, 16'h0000, 16'hFFFF);
    send_circle(16'h5555, 16'hAAAA, 16'h5555);
    send_circle(16'hAAAA, 16'h5555, 16'hAAAA);
    send_circle(mid_x, 16'd0, 16'd1);
    send_circle(16'd0, mid_y, 16'd1);
    send_circle(mid_x + 16'd1, mid_y - 16'd1, 16'd8);
  endtask

  task automatic test_random(int unsigned count);
    logic [15:0] cx, cy, a;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          cx = 16'($urandom); cy = 16'($urandom); a = 16'($urandom);
        end
        1: begin
          // near the image, a plausible ball size
          cx = 16'($urandom_range(0, 16 * width_q));
          cy = 16'($urandom_range(0, 16 * height_q));
          a = 16'($urandom_range(16, 1600));
        end
        2: begin
          cx = 16'($urandom); cy = 16'($urandom); a = 16'($urandom_range(0, 3));
        end
        default: begin
          cx = 16'((width_q >> 1) << 4) + 16'($urandom_range(0, 64)) - 16'd32;
          cy = 16'((height_q >> 1) << 4) + 16'($urandom_range(0, 64)) - 16'd32;
          a = 16'($urandom_range(1, 65535));
        end
      endcase
      send_circle(cx, cy, a);
    end
  endtask

  initial begin
    focal_q = bpic_pkg::FocalRst;
    width_q = bpic_pkg::WidthRst;
    height_q = bpic_pkg::HeightRst;
    ball_q = bpic_pkg::BallRst;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(300);
    set_camera(16'd1, 16'd1, 16'd1, 16'd1);
    test_directed();
    test_random(200);
    set_camera(16'hFFFF, 16'd4096, 16'd4096, 16'hFFFF);
    test_directed();
    test_random(300);
    set_camera(16'd0, 16'h1FFF, 16'h1FFF, 16'd0);
    test_directed();
    test_random(100);
    set_camera(16'd2000, 16'd1920, 16'd1080, 16'd0);
    test_random(100);
    set_camera(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 4096)),
               16'($urandom_range(1, 4096)), 16'($urandom_range(1, 65535)));
    test_directed();
    test_random(300);
    set_camera(16'd8864, 16'd640, 16'd480, 16'd576);
    test_random(200);
    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
